/* hw/rtl/tcw_pkg.sv */
// tcw_pkg: shared types and constants for the text console writer
// transfer payload structs, command and character codes, sequencer states
// no dependencies
package tcw_pkg;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 24;

   // field widths of the transfers
   localparam int COMMAND_W     = 2;
   localparam int CHAR_W        = 8;
   localparam int COLUMN_W      = 7;
   localparam int ROW_W         = 5;
   localparam int CURSOR_CELL_W = 11;

   // command codes
   localparam logic [COMMAND_W-1:0] CMD_PUT_CHAR   = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_SET_CURSOR = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_READ_CELL  = 2'd2;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_LF       = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR       = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_BLANK    = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'd127;

   typedef struct packed {
      logic [COMMAND_W-1:0] command;
      logic [CHAR_W-1:0]    char_code;
      logic [COLUMN_W-1:0]  column;
      logic [ROW_W-1:0]     row;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]        read_char;
      logic [CURSOR_CELL_W-1:0] cursor_cell;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCROLL,
      ST_BLANK,
      ST_APPLY,
      ST_NORM,
      ST_READ,
      ST_FINISH
   } state_type;

endpackage

/* hw/rtl/tcw_mem.sv */
// tcw_mem: character store, one write port and one registered read port
// depends on tcw_pkg for the character width
module tcw_mem #(
   parameter  int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [tcw_pkg::CHAR_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [tcw_pkg::CHAR_W-1:0] rd_data
);

   logic [tcw_pkg::CHAR_W-1:0] chars_ff [DEPTH];
   logic [tcw_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         chars_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= chars_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tcw_ctrl.sv */
// tcw_ctrl: command sequencer, cursor state and store walks (scroll, blank, clear)
// depends on tcw_pkg; drives the ports of tcw_mem
module tcw_ctrl #(
   parameter  int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter  int ROWS    = tcw_pkg::DEF_ROWS,
   localparam int CELLS   = COLUMNS * ROWS,
   localparam int ADDR_W  = $clog2(CELLS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  tcw_pkg::req_type           req_data,
   output logic                       req_stall,
   output logic                       res_valid,
   output tcw_pkg::rsp_type           res_data,
   input  logic                       res_ack,
   output logic                       mem_wr_en,
   output logic [ADDR_W-1:0]          mem_wr_addr,
   output logic [tcw_pkg::CHAR_W-1:0] mem_wr_data,
   output logic                       mem_rd_en,
   output logic [ADDR_W-1:0]          mem_rd_addr,
   input  logic [tcw_pkg::CHAR_W-1:0] mem_rd_data
);

   // largest set-cursor sum and largest cursor after a line feed
   localparam int SetMax    = (2**tcw_pkg::ROW_W - 1) * COLUMNS + 2**tcw_pkg::COLUMN_W - 1;
   localparam int CursorMax = CELLS + COLUMNS - 1;
   localparam int IDX_W     = $clog2((SetMax > CursorMax ? SetMax : CursorMax) + 1);
   localparam int COL_W     = $clog2(COLUMNS + 2**tcw_pkg::COLUMN_W);
   localparam int RROW_W    = $clog2(ROWS + 2**tcw_pkg::ROW_W);

   tcw_pkg::state_type         state_ff, state_in;
   tcw_pkg::state_type         ret_ff, ret_in;
   tcw_pkg::req_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [IDX_W-1:0]           ptr_ff, ptr_in;
   logic [IDX_W-1:0]           end_ff, end_in;
   logic                       copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::CHAR_W-1:0] res_char_ff, res_char_in;

   logic [IDX_W-1:0]           req_sum;
   logic                       req_in_range;
   logic [IDX_W-1:0]           lf_idx;
   logic [tcw_pkg::CHAR_W-1:0] ch;

   assign req_sum = IDX_W'(req_data.row) * IDX_W'(COLUMNS) + IDX_W'(req_data.column);
   assign req_in_range = (COL_W'(req_data.column) < COL_W'(COLUMNS))
                         && (RROW_W'(req_data.row) < RROW_W'(ROWS));
   assign lf_idx = idx_ff + IDX_W'(COLUMNS);
   assign ch     = cmd_ff.char_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_BLANK;
         ret_ff       <= tcw_pkg::ST_IDLE;
         ptr_ff       <= '0;
         end_ff       <= IDX_W'(CELLS);
         idx_ff       <= IDX_W'(CELLS);
         col_ff       <= '0;
         copy_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         ptr_ff       <= ptr_in;
         end_ff       <= end_in;
         idx_ff       <= idx_in;
         col_ff       <= col_in;
         copy_pend_ff <= copy_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      wr_ptr_ff   <= wr_ptr_in;
      res_char_ff <= res_char_in;
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      col_in       = col_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      copy_pend_in = copy_pend_ff;
      wr_ptr_in    = wr_ptr_ff;
      res_char_in  = res_char_ff;
      req_stall    = 1'b1;
      res_valid    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ADDR_W'(ptr_ff);
      mem_wr_data  = tcw_pkg::CHAR_BLANK;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ADDR_W'(ptr_ff);

      unique case (state_ff)
         tcw_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in      = req_data;
               res_char_in = '0;
               unique case (req_data.command)
                  tcw_pkg::CMD_PUT_CHAR: begin
                     if (idx_ff >= IDX_W'(CELLS)) begin
                        state_in     = tcw_pkg::ST_SCROLL;
                        ptr_in       = IDX_W'(COLUMNS);
                        copy_pend_in = 1'b0;
                     end else begin
                        state_in = tcw_pkg::ST_APPLY;
                     end
                  end
                  tcw_pkg::CMD_SET_CURSOR: begin
                     if (req_sum >= IDX_W'(CELLS)) begin
                        idx_in   = IDX_W'(CELLS);
                        col_in   = '0;
                        state_in = tcw_pkg::ST_FINISH;
                     end else begin
                        idx_in   = req_sum;
                        col_in   = COL_W'(req_data.column);
                        state_in = tcw_pkg::ST_NORM;
                     end
                  end
                  tcw_pkg::CMD_READ_CELL: begin
                     if (req_in_range) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = ADDR_W'(req_sum);
                        state_in    = tcw_pkg::ST_READ;
                     end else begin
                        state_in = tcw_pkg::ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = tcw_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         tcw_pkg::ST_SCROLL: begin
            // read cell i, write it back one row up in the following cycle
            if (ptr_ff < IDX_W'(CELLS)) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = ADDR_W'(ptr_ff);
               ptr_in       = ptr_ff + IDX_W'(1);
               copy_pend_in = 1'b1;
               wr_ptr_in    = ADDR_W'(ptr_ff - IDX_W'(COLUMNS));
            end else begin
               copy_pend_in = 1'b0;
            end
            if (copy_pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ptr_ff;
               mem_wr_data = mem_rd_data;
            end
            if ((ptr_ff >= IDX_W'(CELLS)) && !copy_pend_ff) begin
               state_in = tcw_pkg::ST_BLANK;
               ptr_in   = IDX_W'(CELLS - COLUMNS);
               end_in   = IDX_W'(CELLS);
               ret_in   = tcw_pkg::ST_APPLY;
               idx_in   = IDX_W'(CELLS - COLUMNS);
               col_in   = '0;
            end
         end

         tcw_pkg::ST_BLANK: begin
            if (ptr_ff < end_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ADDR_W'(ptr_ff);
               ptr_in      = ptr_ff + IDX_W'(1);
            end else begin
               state_in = ret_ff;
            end
         end

         tcw_pkg::ST_APPLY: begin
            state_in = tcw_pkg::ST_FINISH;
            priority if ((ch >= tcw_pkg::CHAR_PRINT_LO) && (ch <= tcw_pkg::CHAR_PRINT_HI)) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = ADDR_W'(idx_ff);
               mem_wr_data = ch;
               idx_in      = idx_ff + IDX_W'(1);
               col_in      = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
            end else if (ch == tcw_pkg::CHAR_CR) begin
               idx_in = idx_ff - IDX_W'(col_ff);
               col_in = '0;
            end else if (ch == tcw_pkg::CHAR_LF) begin
               idx_in = lf_idx;
               if (lf_idx < IDX_W'(CELLS)) begin
                  // blank from the cursor to the end of the new row
                  ptr_in   = lf_idx;
                  end_in   = lf_idx + IDX_W'(COLUMNS) - IDX_W'(col_ff);
                  ret_in   = tcw_pkg::ST_FINISH;
                  state_in = tcw_pkg::ST_BLANK;
               end
            end else begin
               state_in = tcw_pkg::ST_FINISH;
            end
         end

         tcw_pkg::ST_NORM: begin
            if (col_ff >= COL_W'(COLUMNS)) begin
               col_in = col_ff - COL_W'(COLUMNS);
            end else begin
               state_in = tcw_pkg::ST_FINISH;
            end
         end

         tcw_pkg::ST_READ: begin
            res_char_in = mem_rd_data;
            state_in    = tcw_pkg::ST_FINISH;
         end

         tcw_pkg::ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ack) begin
               state_in = tcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      res_data.read_char   = res_char_ff;
      res_data.cursor_cell = tcw_pkg::CURSOR_CELL_W'(idx_ff);
   end

endmodule

/* hw/rtl/text_console_writer.sv */
// text_console_writer: text-mode console over a ROWS x COLUMNS character store
// depends on tcw_pkg, tcw_ctrl and tcw_mem
//
//   channel  | ports                           | direction | carries
//   ---------+---------------------------------+-----------+--------------------------
//   request  | req_valid, req_stall, req_data  | in        | command, char, column, row
//   response | rsp_valid, rsp_stall, rsp_data  | out       | read_char, cursor_cell
//
// paths: put (printable, cr, other bytes) goes through the apply state, an
//   in-range read through the read state and an in-range set cursor through the
//   normalise state; unused command, out-of-range read and set cursor past the end
//   go straight to the response state; a set cursor column past the row width wraps
//   one row per normalise step; lf on a visible row blanks the rest of that row and
//   a scroll runs a copy walk plus a last-row blank, through the single write port
// reset: a clearing pass (one write per cell, then back to idle) writes spaces
//   to the store before the first request transfer is taken
// stalls: a finished result waits in the output register, a new request is
//   taken meanwhile and its result holds in the sequencer until the register frees
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
   parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tcw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tcw_pkg::rsp_type rsp_data
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   // sequencer to result register
   logic             res_valid;
   logic             res_ack;
   tcw_pkg::rsp_type res_data;

   // store ports
   logic                       mem_wr_en;
   logic [ADDR_W-1:0]          mem_wr_addr;
   logic [tcw_pkg::CHAR_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [ADDR_W-1:0]          mem_rd_addr;
   logic [tcw_pkg::CHAR_W-1:0] mem_rd_data;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .res_ack     (res_ack),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   tcw_mem #(
      .DEPTH (CELLS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result moves in when the register is empty or being drained this cycle
   assign res_ack = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* verif/tb_text_console_writer.sv */
// tb_text_console_writer: self-checking bench for the text console writer
// drives command transfers, mirrors the character store and cursor, checks each result
// depends on tcw_pkg and text_console_writer
`timescale 1ns / 1ps

module tb_text_console_writer;

   // geometry of the instance under test, default parameters
   localparam int COLS  = tcw_pkg::DEF_COLUMNS;
   localparam int LINES = tcw_pkg::DEF_ROWS;
   localparam int CELLS = COLS * LINES;

   // command code the package leaves unnamed, must change nothing
   localparam logic [tcw_pkg::COMMAND_W-1:0] CMD_UNUSED = 2'd3;

   // generous cycle limit: reset clearing pass plus every command scrolling
   // against worst-case stalls, taken several times over
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int RANDOM_COUNT = 500;

   // mirror of the console: store contents, cursor and the replies still owed
   class console_shadow;
      logic [tcw_pkg::CHAR_W-1:0] screen [CELLS];
      int                         cursor;
      tcw_pkg::rsp_type           replies_due [$];
      int                         mismatches;
      int                         checked;
      int                         commands;
      int                         scrolls;
      int                         reads;

      function new();
         foreach (screen[i]) screen[i] = tcw_pkg::CHAR_BLANK;
         cursor     = CELLS;
         mismatches = 0;
         checked    = 0;
         commands   = 0;
         scrolls    = 0;
         reads      = 0;
      endfunction

      // work out the reply to one accepted command and update the mirror
      function void note_command(tcw_pkg::req_type cmd);
         tcw_pkg::rsp_type reply;
         int               idx;
         int               row_end;
         reply = '0;
         commands++;
         case (cmd.command)
            tcw_pkg::CMD_PUT_CHAR: begin
               // scroll check comes first, whatever the byte
               if (cursor >= CELLS) begin
                  for (int i = COLS; i < CELLS; i++) screen[i-COLS] = screen[i];
                  for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = tcw_pkg::CHAR_BLANK;
                  cursor = CELLS - COLS;
                  scrolls++;
               end
               if (cmd.char_code >= tcw_pkg::CHAR_PRINT_LO
                   && cmd.char_code <= tcw_pkg::CHAR_PRINT_HI) begin
                  screen[cursor] = cmd.char_code;
                  cursor++;
               end else if (cmd.char_code == tcw_pkg::CHAR_CR) begin
                  cursor = (cursor / COLS) * COLS;
               end else if (cmd.char_code == tcw_pkg::CHAR_LF) begin
                  cursor += COLS;
                  // still visible: blank from the cursor to the end of its row
                  if (cursor < CELLS) begin
                     row_end = (cursor / COLS + 1) * COLS;
                     for (int i = cursor; i < row_end; i++) screen[i] = tcw_pkg::CHAR_BLANK;
                  end
               end
            end
            tcw_pkg::CMD_SET_CURSOR: begin
               // wide columns wrap into later rows, past the end saturates
               idx    = int'(cmd.row) * COLS + int'(cmd.column);
               cursor = (idx >= CELLS) ? CELLS : idx;
            end
            tcw_pkg::CMD_READ_CELL: begin
               reads++;
               if (int'(cmd.column) < COLS && int'(cmd.row) < LINES)
                  reply.read_char = screen[int'(cmd.row) * COLS + int'(cmd.column)];
            end
            default: ;
         endcase
         reply.cursor_cell = cursor[tcw_pkg::CURSOR_CELL_W-1:0];
         replies_due.push_back(reply);
      endfunction

      // compare one accepted result with the oldest reply owed
      function void check_reply(tcw_pkg::rsp_type got);
         tcw_pkg::rsp_type want;
         if (replies_due.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, got);
            mismatches++;
            return;
         end
         want = replies_due.pop_front();
         checked++;
         if (got.read_char !== want.read_char) begin
            $display("%0t: read_char expected %h actual %h", $time,
                     want.read_char, got.read_char);
            mismatches++;
         end
         if (got.cursor_cell !== want.cursor_cell) begin
            $display("%0t: cursor_cell expected %0d actual %0d", $time,
                     want.cursor_cell, got.cursor_cell);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   tcw_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   tcw_pkg::rsp_type rsp_data;

   console_shadow board = new();

   // random idling on both sides, switched off for a long stretch mid-run
   bit idling_on = 1'b1;
   int cycle_count = 0;
   int last_row = LINES - 1;

   text_console_writer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  board.replies_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   // result side back-pressure, random in about a quarter of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= idling_on && ($urandom_range(99) < 26);
      end
   end

   // monitor: both channels sampled at the edge where a transfer happens
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_command(req_data);
         if (rsp_valid && !rsp_stall) board.check_reply(rsp_data);
      end
   end

   // present one command and hold it until its transfer; valid stays high
   // afterwards so back-to-back commands need no second assignment
   task automatic issue(input logic [tcw_pkg::COMMAND_W-1:0] cmd,
                        input logic [tcw_pkg::CHAR_W-1:0] ch,
                        input int col, input int row);
      tcw_pkg::req_type item;
      item.command   = cmd;
      item.char_code = ch;
      item.column    = col[tcw_pkg::COLUMN_W-1:0];
      item.row       = row[tcw_pkg::ROW_W-1:0];
      while (idling_on && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold the sender off until every owed result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.replies_due.size() != 0);
   endtask

   initial begin
      int                            pick;
      int                            col;
      int                            row;
      logic [tcw_pkg::CHAR_W-1:0]    ch;
      logic [tcw_pkg::COMMAND_W-1:0] cmd;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: fresh store reads spaces, cursor parked past the end
      issue(tcw_pkg::CMD_READ_CELL, 8'h00, 0, 0);
      // read outside the screen, all field bits high
      issue(tcw_pkg::CMD_READ_CELL, 8'hff, 127, 31);
      issue(CMD_UNUSED, 8'h5a, 3, 2);
      // first put scrolls before writing
      issue(tcw_pkg::CMD_PUT_CHAR, "A", 0, 0);
      // control byte and high byte only do the scroll check
      issue(tcw_pkg::CMD_PUT_CHAR, 8'h00, 127, 31);
      issue(tcw_pkg::CMD_PUT_CHAR, 8'hff, 0, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_PRINT_HI, 0, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_PRINT_LO, 0, 0);
      issue(tcw_pkg::CMD_READ_CELL, 8'h00, 0, LINES - 1);
      // cr then lf on the bottom row pushes the cursor off screen, no blank
      issue(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_CR, 0, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_LF, 0, 0);
      // top-left corner and last column of the top row
      issue(tcw_pkg::CMD_SET_CURSOR, 8'h00, 0, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, "B", 0, 0);
      issue(tcw_pkg::CMD_SET_CURSOR, 8'h00, COLS - 1, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, "C", 0, 0);
      // mid-row lf blanks the remainder of the next row
      issue(tcw_pkg::CMD_SET_CURSOR, 8'h00, 5, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CHAR_LF, 0, 0);
      // wide column wraps, far position saturates
      issue(tcw_pkg::CMD_SET_CURSOR, 8'h00, 127, 0);
      issue(tcw_pkg::CMD_SET_CURSOR, 8'h00, 127, 31);
      // last visible cell, then a put that runs off the end and scrolls
      issue(tcw_pkg::CMD_SET_CURSOR, 8'h00, COLS - 1, LINES - 1);
      issue(tcw_pkg::CMD_PUT_CHAR, "Z", 0, 0);
      issue(tcw_pkg::CMD_PUT_CHAR, "x", 0, 0);
      issue(tcw_pkg::CMD_READ_CELL, 8'h00, COLS - 1, LINES - 2);
      issue(tcw_pkg::CMD_READ_CELL, 8'h00, 0, 0);

      // random: mostly text runs, line controls and cursor moves with reads
      // near written rows, some noise and out-of-range fields
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         if (n == 150) idling_on = 1'b0;
         if (n == 270) idling_on = 1'b1;
         if (n == 350) drain();
         pick = $urandom_range(99);
         cmd  = tcw_pkg::CMD_PUT_CHAR;
         ch   = tcw_pkg::CHAR_W'($urandom_range(tcw_pkg::CHAR_PRINT_LO,
                                                tcw_pkg::CHAR_PRINT_HI));
         col  = $urandom_range(127);
         row  = $urandom_range(31);
         if (pick < 55) begin
            // printable, ignored fields left random
         end else if (pick < 62) begin
            ch = tcw_pkg::CHAR_CR;
         end else if (pick < 68) begin
            ch = tcw_pkg::CHAR_LF;
         end else if (pick < 71) begin
            ch = tcw_pkg::CHAR_W'($urandom_range(255));
         end else if (pick < 80) begin
            cmd = tcw_pkg::CMD_SET_CURSOR;
            if ($urandom_range(9) != 0) begin
               col = $urandom_range(COLS - 1);
               row = $urandom_range(LINES - 1);
            end
            last_row = (row < LINES) ? row : LINES - 1;
         end else if (pick < 96) begin
            cmd = tcw_pkg::CMD_READ_CELL;
            if ($urandom_range(15) != 0) begin
               col = $urandom_range(COLS - 1);
               case ($urandom_range(3))
                  0:       row = last_row;
                  1:       row = LINES - 1;
                  2:       row = LINES - 2;
                  default: row = $urandom_range(LINES - 1);
               endcase
            end
         end else begin
            cmd = CMD_UNUSED;
            ch  = tcw_pkg::CHAR_W'($urandom_range(255));
         end
         issue(cmd, ch, col, row);
      end

      // wait out every owed result, then keep watching for stray results
      drain();
      repeat (2 * CELLS + 50) @(posedge clock);

      $display("ran %0d commands with %0d scrolls and %0d cell reads", board.commands,
               board.scrolls, board.reads);
      $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.replies_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_mem.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer.sv
verif/tb_text_console_writer.sv
